// ----- hw/rtl/matrix3x3_arith_unit_top_defines.svh -----
// assertion macros for the matrix unit rtl
`ifndef MATRIX3X3_ARITH_UNIT_TOP_DEFINES_SVH
`define MATRIX3X3_ARITH_UNIT_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define M3AU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("m3au check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define M3AU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("m3au check failed");

`endif

// ----- hw/rtl/m3au_pkg.sv -----
`default_nettype none

package m3au_pkg;

    localparam int ELEM_W   = 32;
    localparam int IDX_W    = 2;
    localparam int ADDR_W   = 4;
    localparam int DIM      = 3;
    localparam int NUM_ELEM = 9;
    localparam int PROD_W   = 2 * ELEM_W;
    // three full products summed, with headroom
    localparam int ACC_W    = PROD_W + 2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [2:0] {
        FN_LOAD_A,
        FN_LOAD_B,
        FN_LOAD_V,
        FN_ADD,
        FN_SUB,
        FN_MATMUL,
        FN_MATVEC,
        FN_SCALE
    } t_func;

    typedef struct packed {
        t_func                    func;
        t_idx                     row_index;
        t_idx                     col_index;
        logic signed [ELEM_W-1:0] operand_value;
    } t_in_req;

    typedef struct packed {
        t_idx                     out_row;
        t_idx                     out_col;
        logic signed [ELEM_W-1:0] out_value;
        logic                     overflow;
        logic                     last_flag;
    } t_out_res;

    // operand selection for one term of one element
    typedef struct packed {
        t_func func;
        t_idx  row;
        t_idx  col;
        t_idx  term;
    } t_sel;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic issue;
        logic first;
        logic shift_en;
    } t_mac_ctl;

    function automatic t_addr elem_addr(t_idx r, t_idx c);
        return ADDR_W'(r) * ADDR_W'(DIM) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/m3au_store.sv -----
`default_nettype none

module m3au_store (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire m3au_pkg::t_in_req                i_wr_req,
    input  wire m3au_pkg::t_sel                   i_sel,
    input  wire logic signed [m3au_pkg::ELEM_W-1:0] i_scalar,
    output logic signed [m3au_pkg::ELEM_W-1:0]   o_op_x,
    output logic signed [m3au_pkg::ELEM_W-1:0]   o_op_y
);
    import m3au_pkg::*;

    localparam logic signed [ELEM_W-1:0] ONE       = ELEM_W'(1);
    localparam logic signed [ELEM_W-1:0] MINUS_ONE = -ELEM_W'(1);

    logic signed [ELEM_W-1:0] r_mat_a [NUM_ELEM];
    logic signed [ELEM_W-1:0] r_mat_b [NUM_ELEM];
    logic signed [ELEM_W-1:0] r_vec   [DIM];

    t_addr w_wr_addr;
    logic  w_wr_row_ok;
    logic  w_wr_col_ok;
    t_addr w_a_addr;
    t_addr w_b_addr;
    logic signed [ELEM_W-1:0] w_a;
    logic signed [ELEM_W-1:0] w_b;

    assign w_wr_addr   = elem_addr(i_wr_req.row_index, i_wr_req.col_index);
    assign w_wr_row_ok = (i_wr_req.row_index < IDX_W'(DIM));
    assign w_wr_col_ok = (i_wr_req.col_index < IDX_W'(DIM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ELEM; i++) begin
                r_mat_a[i] <= '0;
                r_mat_b[i] <= '0;
            end
            for (int i = 0; i < DIM; i++) begin
                r_vec[i] <= '0;
            end
        end else if (i_wr_en) begin
            case (i_wr_req.func)
                FN_LOAD_A: begin
                    if (w_wr_row_ok && w_wr_col_ok) begin
                        r_mat_a[w_wr_addr] <= i_wr_req.operand_value;
                    end
                end
                FN_LOAD_B: begin
                    if (w_wr_row_ok && w_wr_col_ok) begin
                        r_mat_b[w_wr_addr] <= i_wr_req.operand_value;
                    end
                end
                FN_LOAD_V: begin
                    if (w_wr_row_ok) begin
                        r_vec[i_wr_req.row_index] <= i_wr_req.operand_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // products walk along a row of a; matmul walks down a column of b
    assign w_a_addr = (i_sel.func inside {FN_MATMUL, FN_MATVEC}) ?
                      elem_addr(i_sel.row, i_sel.term) : elem_addr(i_sel.row, i_sel.col);
    assign w_b_addr = (i_sel.func == FN_MATMUL) ?
                      elem_addr(i_sel.term, i_sel.col) : elem_addr(i_sel.row, i_sel.col);
    assign w_a = r_mat_a[w_a_addr];
    assign w_b = r_mat_b[w_b_addr];

    always_comb begin
        o_op_x = '0;
        o_op_y = '0;
        case (i_sel.func)
            FN_ADD, FN_SUB: begin
                // a*1 then b*(+/-1), third term empty
                if (i_sel.term == 2'd0) begin
                    o_op_x = w_a;
                    o_op_y = ONE;
                end else if (i_sel.term == 2'd1) begin
                    o_op_x = w_b;
                    o_op_y = (i_sel.func == FN_SUB) ? MINUS_ONE : ONE;
                end
            end
            FN_MATMUL: begin
                o_op_x = w_a;
                o_op_y = w_b;
            end
            FN_MATVEC: begin
                o_op_x = w_a;
                o_op_y = r_vec[i_sel.term];
            end
            FN_SCALE: begin
                if (i_sel.term == 2'd0) begin
                    o_op_x = w_a;
                    o_op_y = i_scalar;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/m3au_mac.sv -----
`default_nettype none

module m3au_mac #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire m3au_pkg::t_mac_ctl                 i_ctl,
    input  wire logic signed [m3au_pkg::ELEM_W-1:0] i_op_x,
    input  wire logic signed [m3au_pkg::ELEM_W-1:0] i_op_y,
    output logic signed [m3au_pkg::ELEM_W-1:0]     o_value,
    output logic                                    o_overflow
);
    import m3au_pkg::*;

    localparam int HEAD_W = ACC_W - DATA_WIDTH + 1;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        (ACC_W'(1) << (DATA_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_pfirst;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_shifted;
    logic [HEAD_W-1:0]        w_head;
    logic                     w_in_range;

    assign w_prod = i_op_x * i_op_y;

    always_ff @(posedge i_clk) begin
        r_prod   <= w_prod;
        r_pfirst <= i_ctl.first;
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_acc <= r_pfirst ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    // arithmetic shift, then clamp to the signed data range
    assign w_shifted  = i_ctl.shift_en ? (r_acc >>> FRAC_BITS) : r_acc;
    assign w_head     = w_shifted[ACC_W-1:DATA_WIDTH-1];
    assign w_in_range = (&w_head) || !(|w_head);

    always_comb begin
        o_overflow = !w_in_range;
        if (w_in_range) begin
            o_value = w_shifted[ELEM_W-1:0];
        end else if (w_shifted[ACC_W-1]) begin
            o_value = SAT_MIN[ELEM_W-1:0];
        end else begin
            o_value = SAT_MAX[ELEM_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/matrix3x3_arith_unit_top.sv -----
`default_nettype none

// 3x3 fixed-point matrix unit. A request either loads one element of matrix A,
// matrix B or the 3-element vector (no result), or starts an operation: A+B,
// A-B, A*B, A*vector, or A times the scalar carried in operand_value. Results
// come out in row-major order, one result per element, with last_flag on the
// final one; matvec gives three results with column 0. Every element is a sum
// of three terms pushed through one shared 32x32 multiplier and a wide
// accumulator: three multiply issues (S_RUN), one drain state (S_SUM) in which
// the last product lands in the accumulator, and one emit state (S_EMIT) that
// shifts, saturates and loads the output register, and that waits there
// while the output is stalled.
// The input stalls for the whole of an operation. Multiply results are shifted
// right arithmetically by FRAC_BITS before saturation to DATA_WIDTH signed bits;
// add and subtract are not shifted. overflow marks a saturated element.
module matrix3x3_arith_unit_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire m3au_pkg::t_in_req  i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output m3au_pkg::t_out_res      o_out_res
);
    import m3au_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_SUM,
        S_EMIT
    } t_state;

    t_state   r_state, n_state;
    t_func    r_func, n_func;
    logic signed [ELEM_W-1:0] r_scalar, n_scalar;
    t_idx     r_row, n_row;
    t_idx     r_col, n_col;
    t_idx     r_term, n_term;
    logic     r_out_valid, n_out_valid;
    t_out_res r_out, n_out;

    logic     w_accept;
    logic     w_is_op;
    logic     w_out_free;
    logic     w_elem_last;
    t_sel     w_sel;
    t_mac_ctl w_mac_ctl;
    logic signed [ELEM_W-1:0] w_op_x;
    logic signed [ELEM_W-1:0] w_op_y;
    logic signed [ELEM_W-1:0] w_mac_value;
    logic     w_mac_ovf;

    // only idle takes requests; loads finish in the accepting cycle
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_is_op    = !(i_in_req.func inside {FN_LOAD_A, FN_LOAD_B, FN_LOAD_V});

    // output register frees up in the same cycle its request is taken
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_elem_last = (r_row == 2'd2) && ((r_func == FN_MATVEC) || (r_col == 2'd2));

    assign w_sel = '{func: r_func, row: r_row, col: r_col, term: r_term};

    // add and subtract bypass the fraction shift
    assign w_mac_ctl = '{
        issue:    (r_state == S_RUN),
        first:    (r_term == 2'd0),
        shift_en: !(r_func inside {FN_ADD, FN_SUB})
    };

    m3au_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_accept),
        .i_wr_req (i_in_req),
        .i_sel    (w_sel),
        .i_scalar (r_scalar),
        .o_op_x   (w_op_x),
        .o_op_y   (w_op_y)
    );

    m3au_mac #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mac_ctl),
        .i_op_x     (w_op_x),
        .i_op_y     (w_op_y),
        .o_value    (w_mac_value),
        .o_overflow (w_mac_ovf)
    );

    // sequencer: row, column and term counters walk the result elements
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_scalar    = r_scalar;
        n_row       = r_row;
        n_col       = r_col;
        n_term      = r_term;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_is_op) begin
                    n_func   = i_in_req.func;
                    n_scalar = i_in_req.operand_value;
                    n_row    = '0;
                    n_col    = '0;
                    n_term   = '0;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                // one term issued to the multiplier per cycle
                if (r_term == 2'd2) begin
                    n_term  = '0;
                    n_state = S_SUM;
                end else begin
                    n_term = r_term + 2'd1;
                end
            end
            S_SUM: begin
                // last product lands in the accumulator
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{
                        out_row:   r_row,
                        out_col:   r_col,
                        out_value: w_mac_value,
                        overflow:  w_mac_ovf,
                        last_flag: w_elem_last
                    };
                    if (w_elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RUN;
                        if ((r_func == FN_MATVEC) || (r_col == 2'd2)) begin
                            n_row = r_row + 2'd1;
                            n_col = '0;
                        end else begin
                            n_col = r_col + 2'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_scalar <= n_scalar;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_term      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_term      <= n_term;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

`include "matrix3x3_arith_unit_top_defines.svh"

    // an operation always starts at the first element, first term
    `M3AU_ASSERT_NXT(a_op_start, w_accept && w_is_op, r_state == S_RUN && r_row == 2'd0 && r_col == 2'd0 && r_term == 2'd0)

    // terms are issued back to back in order
    `M3AU_ASSERT_NXT(a_term_seq, r_state == S_RUN && r_term != 2'd2, r_state == S_RUN && r_term == $past(r_term) + 2'd1)

    // a blocked output holds the finished element back
    `M3AU_ASSERT_NXT(a_emit_hold, r_state == S_EMIT && r_out_valid && i_out_stall, r_state == S_EMIT)

    // the final element always sits in the last row
    `M3AU_ASSERT_IMP(a_last_row, r_out_valid && r_out.last_flag, r_out.out_row == 2'd2)

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import m3au_pkg::*;

    localparam int FRAC           = 16;
    // exact element width: three 64-bit products plus headroom
    localparam int WIDE_W         = 68;
    localparam int LONG_HOLD      = 150;
    // the watchdog limit covers a nine-element operation, the long hold and receiver stalls
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int ITEMS_PER_MIX  = 26;

    localparam logic signed [WIDE_W-1:0] ELEM_MAX = 68'sd2147483647;
    localparam logic signed [WIDE_W-1:0] ELEM_MIN = -68'sd2147483648;

    // scoreboard: mirrors the A, B and vector stores and queues the elements each
    // operation should produce, in row-major order
    class matrix_scoreboard;
        logic signed [ELEM_W-1:0] mat_a [NUM_ELEM];
        logic signed [ELEM_W-1:0] mat_b [NUM_ELEM];
        logic signed [ELEM_W-1:0] vec [DIM];
        t_out_res pending_elems [$];
        int mismatches;
        int loads_seen;
        int ops_seen;
        int elems_checked;

        function new();
            foreach (mat_a[i]) mat_a[i] = '0;
            foreach (mat_b[i]) mat_b[i] = '0;
            foreach (vec[i]) vec[i] = '0;
            mismatches    = 0;
            loads_seen    = 0;
            ops_seen      = 0;
            elems_checked = 0;
        endfunction

        function logic signed [WIDE_W-1:0] widen(logic signed [ELEM_W-1:0] x);
            logic signed [WIDE_W-1:0] w;
            w = x;
            return w;
        endfunction

        // shift (for multiplies), saturate and tag one element
        function void queue_element(logic signed [WIDE_W-1:0] exact, bit scaled, int r, int c,
                                    bit last);
            logic signed [WIDE_W-1:0] v;
            t_out_res elem;
            v = scaled ? (exact >>> FRAC) : exact;
            elem.out_row   = t_idx'(r);
            elem.out_col   = t_idx'(c);
            elem.last_flag = last;
            if (v > ELEM_MAX) begin
                elem.out_value = ELEM_MAX[ELEM_W-1:0];
                elem.overflow  = 1'b1;
            end else if (v < ELEM_MIN) begin
                elem.out_value = ELEM_MIN[ELEM_W-1:0];
                elem.overflow  = 1'b1;
            end else begin
                elem.out_value = v[ELEM_W-1:0];
                elem.overflow  = 1'b0;
            end
            pending_elems.push_back(elem);
        endfunction

        function void note_request(t_in_req req);
            logic signed [WIDE_W-1:0] acc;
            int idx;
            case (req.func)
                FN_LOAD_A, FN_LOAD_B: begin
                    loads_seen++;
                    // out-of-range index leaves the stores alone
                    if (req.row_index < DIM && req.col_index < DIM) begin
                        idx = req.row_index * DIM + req.col_index;
                        if (req.func == FN_LOAD_A) mat_a[idx] = req.operand_value;
                        else mat_b[idx] = req.operand_value;
                    end
                end
                FN_LOAD_V: begin
                    loads_seen++;
                    if (req.row_index < DIM) vec[req.row_index] = req.operand_value;
                end
                FN_MATVEC: begin
                    ops_seen++;
                    for (int r = 0; r < DIM; r++) begin
                        acc = '0;
                        for (int k = 0; k < DIM; k++)
                            acc = acc + widen(mat_a[r*DIM+k]) * widen(vec[k]);
                        queue_element(acc, 1'b1, r, 0, r == DIM-1);
                    end
                end
                default: begin
                    ops_seen++;
                    for (int r = 0; r < DIM; r++) begin
                        for (int c = 0; c < DIM; c++) begin
                            idx = r * DIM + c;
                            case (req.func)
                                FN_ADD: acc = widen(mat_a[idx]) + widen(mat_b[idx]);
                                FN_SUB: acc = widen(mat_a[idx]) - widen(mat_b[idx]);
                                FN_MATMUL: begin
                                    acc = '0;
                                    for (int k = 0; k < DIM; k++)
                                        acc = acc + widen(mat_a[r*DIM+k]) * widen(mat_b[k*DIM+c]);
                                end
                                default: acc = widen(mat_a[idx]) * widen(req.operand_value);
                            endcase
                            queue_element(acc, req.func != FN_ADD && req.func != FN_SUB, r, c,
                                          r == DIM-1 && c == DIM-1);
                        end
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [ELEM_W-1:0] got, logic [ELEM_W-1:0] want);
            mismatches++;
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        endtask

        task check_result(t_out_res got);
            t_out_res want;
            elems_checked++;
            if (pending_elems.size() == 0) begin
                report_mismatch("unexpected result element", got.out_value, '0);
                return;
            end
            want = pending_elems.pop_front();
            if (got.out_row !== want.out_row)
                report_mismatch("out_row", ELEM_W'(got.out_row), ELEM_W'(want.out_row));
            if (got.out_col !== want.out_col)
                report_mismatch("out_col", ELEM_W'(got.out_col), ELEM_W'(want.out_col));
            if (got.out_value !== want.out_value)
                report_mismatch("out_value", got.out_value, want.out_value);
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", ELEM_W'(got.overflow), ELEM_W'(want.overflow));
            if (got.last_flag !== want.last_flag)
                report_mismatch("last_flag", ELEM_W'(got.last_flag), ELEM_W'(want.last_flag));
        endtask
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_res o_out_res;

    int sender_idle_pct = 26;
    int recv_idle_pct   = 83;
    bit hold_off_request = 1'b0;
    int quiet_cycles    = 0;

    matrix_scoreboard sb = new();

    matrix3x3_arith_unit_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // monitor: both handshakes are sampled at the edge, before any update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_request(i_in_req);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_res);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stall, or one long hold-off on request so the unit backs up
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_in_req make_req(t_func f, int r, int c, logic [ELEM_W-1:0] v);
        t_in_req req;
        req.func          = f;
        req.row_index     = t_idx'(r);
        req.col_index     = t_idx'(c);
        req.operand_value = v;
        return req;
    endfunction

    // mix of extremes, small fixed-point values and raw random words
    function automatic logic [ELEM_W-1:0] random_elem();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly in-range loads and operations with junk indices, a few any-function requests with column 3
    function automatic t_in_req random_req();
        int pick;
        pick = $urandom_range(99);
        if (pick < 68)
            return make_req(t_func'($urandom_range(2)), $urandom_range(2), $urandom_range(2),
                            random_elem());
        else if (pick < 94)
            return make_req(t_func'($urandom_range(7, 3)), $urandom_range(3),
                            $urandom_range(3), random_elem());
        else
            return make_req(t_func'($urandom_range(7)), $urandom_range(3, 0), 3, $urandom);
    endfunction

    // valid stays high from one request to the next unless the sender idles
    task automatic offer_request(t_in_req req);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        repeat (count) offer_request(random_req());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme elements in all three stores, ignored loads, every operation
        offer_request(make_req(FN_LOAD_A, 0, 0, 32'h7fff_ffff));
        offer_request(make_req(FN_LOAD_A, 1, 1, 32'h8000_0000));
        offer_request(make_req(FN_LOAD_A, 2, 2, 32'hffff_ffff));
        offer_request(make_req(FN_LOAD_A, 0, 1, 32'h0001_0000));
        // row 3 is out of range, nothing loads
        offer_request(make_req(FN_LOAD_A, 3, 1, 32'h1234_5678));
        offer_request(make_req(FN_LOAD_B, 0, 0, 32'h7fff_ffff));
        offer_request(make_req(FN_LOAD_B, 1, 1, 32'h8000_0000));
        offer_request(make_req(FN_LOAD_B, 2, 0, 32'h0001_0000));
        offer_request(make_req(FN_LOAD_B, 1, 0, 32'hfffe_0000));
        // column 3 is out of range
        offer_request(make_req(FN_LOAD_B, 1, 3, 32'h5555_aaaa));
        offer_request(make_req(FN_LOAD_V, 0, 2, 32'h7fff_ffff));
        offer_request(make_req(FN_LOAD_V, 1, 0, 32'h8000_0000));
        offer_request(make_req(FN_LOAD_V, 2, 1, 32'h0000_8000));
        // vector index 3 is ignored
        offer_request(make_req(FN_LOAD_V, 3, 3, 32'hdead_beef));
        // operations carry junk indices that must be ignored; only scale uses its operand
        offer_request(make_req(FN_ADD, 3, 3, 32'hffff_ffff));
        offer_request(make_req(FN_SUB, 2, 1, 32'h8000_0000));
        offer_request(make_req(FN_MATMUL, 1, 2, 32'h7fff_ffff));
        offer_request(make_req(FN_MATVEC, 3, 0, 32'h0f0f_0f0f));
        offer_request(make_req(FN_SCALE, 0, 0, 32'h7fff_ffff));
        offer_request(make_req(FN_SCALE, 1, 1, 32'h8000_0000));
        offer_request(make_req(FN_SCALE, 3, 3, 32'h0000_0000));
        offer_request(make_req(FN_SCALE, 2, 2, 32'hffff_0000));

        // sender mostly busy, receiver mostly stalled
        run_random(ITEMS_PER_MIX);
        // swapped
        sender_idle_pct = 83;
        recv_idle_pct   = 26;
        run_random(ITEMS_PER_MIX);
        // back to back, opening with a long output hold-off while requests keep coming
        sender_idle_pct  = 0;
        recv_idle_pct    = 0;
        hold_off_request = 1'b1;
        offer_request(make_req(FN_MATMUL, 0, 0, '0));
        offer_request(make_req(FN_SCALE, 0, 0, 32'h0002_0000));
        run_random(ITEMS_PER_MIX);

        i_in_valid <= 1'b0;
        while (sb.pending_elems.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d load requests and %0d operations, %0d result elements checked",
                 sb.loads_seen, sb.ops_seen, sb.elems_checked);
        $display("idle mixes: busy sender with slow receiver, the reverse, full rate, one long hold-off");
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- matrix3x3_arith_unit_top.f -----
+incdir+hw/rtl
hw/rtl/m3au_pkg.sv
hw/rtl/m3au_store.sv
hw/rtl/m3au_mac.sv
hw/rtl/matrix3x3_arith_unit_top.sv
bench/tb.sv
